/* hw/rtl/wsts_pkg.sv */
// Package: constants, types and rank lookup for the worst status token scan.
package wsts_pkg;

  localparam int MAX_LEVELS = 8;
  localparam int CHAR_W     = 8;
  localparam int RANK_W     = 3;
  localparam int SEV_W      = MAX_LEVELS * CHAR_W;
  localparam int LVLCNT_W   = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CHAR_W-1:0] SEP_CHAR   = 8'h2F;
  localparam logic [CHAR_W-1:0] COLON_CHAR = 8'h3A;
  localparam logic [CHAR_W-1:0] LETTER_E   = 8'h45;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEVERITY  = 4'd0,
    CFG_LEVELS    = 4'd1,
    CFG_UNKNOWN   = 4'd2,
    CFG_UNDEFINED = 4'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TOK_EMPTY = 2'd0,
    TOK_ONE   = 2'd1,
    TOK_COLON = 2'd2,
    TOK_PLAIN = 2'd3
  } tok_pos_t;

  typedef struct packed {
    logic              found;
    logic [RANK_W-1:0] rank;
  } rank_t;

  function automatic logic [CHAR_W-1:0] letter_at(input logic [SEV_W-1:0] sev,
                                                  input logic [RANK_W-1:0] idx);
    return sev[idx*CHAR_W +: CHAR_W];
  endfunction

  function automatic logic [RANK_W-1:0] last_index(input logic [LVLCNT_W-1:0] cnt);
    logic [RANK_W-1:0] r;
    if (cnt == '0) begin
      r = '0;
    end else if (cnt >= LVLCNT_W'(MAX_LEVELS)) begin
      r = RANK_W'(MAX_LEVELS - 1);
    end else begin
      r = RANK_W'(cnt - LVLCNT_W'(1));
    end
    return r;
  endfunction

  // first position of c among the letters in use
  function automatic rank_t find_rank(input logic [SEV_W-1:0]  sev,
                                      input logic [RANK_W-1:0] last_idx,
                                      input logic [CHAR_W-1:0] c);
    rank_t r;
    r.found = 1'b0;
    r.rank  = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if ((RANK_W'(i) <= last_idx) && (sev[i*CHAR_W +: CHAR_W] == c)) begin
        r.found = 1'b1;
        r.rank  = RANK_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/worst_status_token_scan.sv */
// Top level: worst status token scan over a byte stream with config registers.
// A last-of-string transaction passes the stage-1 input register, then the result register.
// Throughput: one transaction per cycle while the input is not stalled; the rank lookup is eight parallel compares.
// Input stalls only when a last-of-string transaction waits on a full result register.
// Reset: synchronous, active low; config returns to defaults and the scan re-arms.
// Any config write re-arms the scan state from the new register values.
module worst_status_token_scan
  import wsts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAR_W-1:0]     in_byte_value,
  input  logic                  in_has_byte,
  input  logic                  in_is_last,
  input  logic                  in_eval_failed,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_worst_char,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [SEV_W-1:0]    sev_r;
  logic [LVLCNT_W-1:0] lvl_cnt_r;
  logic [CHAR_W-1:0]   unk_char_r;
  logic [CHAR_W-1:0]   undef_char_r;

  logic                s1_valid_r;
  logic [CHAR_W-1:0]   s1_byte_r;
  logic                s1_has_r;
  logic                s1_last_r;
  logic                s1_fail_r;

  tok_pos_t            tok_pos_r, tok_pos_nxt;
  logic [CHAR_W-1:0]   tok_first_r, tok_first_nxt;
  logic [RANK_W-1:0]   worst_rank_r;
  logic                fresh_r;
  logic                failed_r;

  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;

  logic                out_free;
  logic                s1_adv;
  logic [RANK_W-1:0]   last_idx;
  rank_t               init_rank;
  logic [RANK_W-1:0]   eff_worst;
  logic                is_sep;
  rank_t               r1, r2;
  logic [RANK_W-1:0]   w1, w2;
  logic                fail_a;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready  = !s1_valid_r || s1_adv;

  assign last_idx  = last_index(lvl_cnt_r);
  assign init_rank = find_rank(sev_r, last_idx, letter_at(sev_r, last_idx));
  assign eff_worst = fresh_r ? init_rank.rank : worst_rank_r;
  assign is_sep    = s1_has_r && (s1_byte_r == SEP_CHAR);
  assign fail_a    = failed_r || s1_fail_r;

  assign r1 = find_rank(sev_r, last_idx,
                        (tok_pos_r == TOK_COLON) ? tok_first_r : unk_char_r);
  assign w1 = (is_sep && r1.found && (r1.rank < eff_worst)) ? r1.rank : eff_worst;

  always_comb begin
    tok_pos_nxt   = tok_pos_r;
    tok_first_nxt = tok_first_r;
    if (s1_has_r) begin
      if (is_sep) begin
        tok_pos_nxt   = TOK_EMPTY;
        tok_first_nxt = '0;
      end else begin
        case (tok_pos_r)
          TOK_EMPTY: begin
            tok_pos_nxt   = TOK_ONE;
            tok_first_nxt = s1_byte_r;
          end
          TOK_ONE: begin
            tok_pos_nxt = (s1_byte_r == COLON_CHAR) ? TOK_COLON : TOK_PLAIN;
          end
          default: begin
            tok_pos_nxt = tok_pos_r;
          end
        endcase
      end
    end
  end

  assign r2 = find_rank(sev_r, last_idx,
                        (tok_pos_nxt == TOK_COLON) ? tok_first_nxt : unk_char_r);
  assign w2 = (r2.found && (r2.rank < w1)) ? r2.rank : w1;

  assign out_char_nxt = fail_a ? undef_char_r : letter_at(sev_r, w2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sev_r        <= '0;
      lvl_cnt_r    <= LVLCNT_W'(1);
      unk_char_r   <= LETTER_E;
      undef_char_r <= LETTER_E;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEVERITY:  sev_r        <= cfg_wdata[SEV_W-1:0];
        CFG_LEVELS:    lvl_cnt_r    <= cfg_wdata[LVLCNT_W-1:0];
        CFG_UNKNOWN:   unk_char_r   <= cfg_wdata[CHAR_W-1:0];
        CFG_UNDEFINED: undef_char_r <= cfg_wdata[CHAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte_value;
      s1_has_r  <= in_has_byte;
      s1_last_r <= in_is_last;
      s1_fail_r <= in_eval_failed;
    end
  end

  // scan state: re-arm on reset, config write or end of string
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we || (s1_adv && s1_last_r)) begin
      tok_pos_r    <= TOK_EMPTY;
      tok_first_r  <= '0;
      failed_r     <= 1'b0;
      fresh_r      <= 1'b1;
      worst_rank_r <= '0;
    end else if (s1_adv) begin
      tok_pos_r    <= tok_pos_nxt;
      tok_first_r  <= tok_first_nxt;
      failed_r     <= fail_a;
      fresh_r      <= 1'b0;
      worst_rank_r <= w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_char_r <= out_char_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_worst_char = out_char_r;

endmodule

/* hw/rtl/wsts_checker.sv */
// Checker: port-level assertions for the worst status token scan, with bind.
module wsts_checker
  import wsts_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_is_last,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [CHAR_W-1:0]     out_worst_char
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_worst_char))
    else $error("result dropped or changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last && (!out_valid || out_ready) ##1
      (!out_valid || out_ready) |=> out_valid)
    else $error("last transaction produced no result");

endmodule

bind worst_status_token_scan wsts_checker u_wsts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_is_last     (in_is_last),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_worst_char (out_worst_char)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Testbench for worst_status_token_scan: status strings scored by a scan model, checked per result.
module testbench;
  import wsts_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_ITEMS    = 230;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd9;
  localparam logic [CHAR_W-1:0]    POOL_BASE = "A";

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_byte_value  = '0;
  logic                  in_has_byte    = 1'b0;
  logic                  in_is_last     = 1'b0;
  logic                  in_eval_failed = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [CHAR_W-1:0]     out_worst_char;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int mismatch_count = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  logic [SEV_W-1:0]    sev_list;
  logic [LVLCNT_W-1:0] lvl_reg;
  logic [CHAR_W-1:0]   unknown_letter;
  logic [CHAR_W-1:0]   undefined_letter;
  tok_pos_t            tok_state;
  logic [CHAR_W-1:0]   tok_lead;
  logic [RANK_W-1:0]   worst_pos;
  logic                fail_flag;
  logic [CHAR_W-1:0]   worst_letters_due[$];

  worst_status_token_scan uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_value  (in_byte_value),
    .in_has_byte    (in_has_byte),
    .in_is_last     (in_is_last),
    .in_eval_failed (in_eval_failed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_worst_char (out_worst_char),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int levels_used();
    if (lvl_reg == '0) return 1;
    if (lvl_reg > MAX_LEVELS) return MAX_LEVELS;
    return int'(lvl_reg);
  endfunction

  function automatic logic [CHAR_W-1:0] list_letter(input int pos);
    return sev_list[pos*CHAR_W +: CHAR_W];
  endfunction

  function automatic bit severity_rank(input logic [CHAR_W-1:0] c,
                                       output logic [RANK_W-1:0] pos);
    pos = '0;
    for (int i = 0; i < levels_used(); i++) begin
      if (list_letter(i) == c) begin
        pos = RANK_W'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void restart_scan();
    logic [RANK_W-1:0] pos;
    tok_state = TOK_EMPTY;
    tok_lead  = '0;
    fail_flag = 1'b0;
    void'(severity_rank(list_letter(levels_used() - 1), pos));
    worst_pos = pos;
  endfunction

  function automatic void close_token();
    logic [CHAR_W-1:0] letter;
    logic [RANK_W-1:0] pos;
    letter = (tok_state == TOK_COLON) ? tok_lead : unknown_letter;
    if (severity_rank(letter, pos) && pos < worst_pos) worst_pos = pos;
    tok_state = TOK_EMPTY;
    tok_lead  = '0;
  endfunction

  function automatic void track_status_byte(input logic [CHAR_W-1:0] b, input logic has,
                                            input logic last, input logic fail);
    if (fail) fail_flag = 1'b1;
    if (has) begin
      if (b == SEP_CHAR) begin
        close_token();
      end else if (tok_state == TOK_EMPTY) begin
        tok_lead  = b;
        tok_state = TOK_ONE;
      end else if (tok_state == TOK_ONE) begin
        tok_state = (b == COLON_CHAR) ? TOK_COLON : TOK_PLAIN;
      end
    end
    if (last) begin
      close_token();
      worst_letters_due.push_back(fail_flag ? undefined_letter : list_letter(worst_pos));
      restart_scan();
    end
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SEVERITY:  sev_list = data;
      CFG_LEVELS:    lvl_reg = data[LVLCNT_W-1:0];
      CFG_UNKNOWN:   unknown_letter = data[CHAR_W-1:0];
      CFG_UNDEFINED: undefined_letter = data[CHAR_W-1:0];
      default: ;
    endcase
    restart_scan();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      track_status_byte(in_byte_value, in_has_byte, in_is_last, in_eval_failed);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (worst_letters_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, worst_char %02h", out_worst_char));
      end else begin
        if (out_worst_char !== worst_letters_due[0]) begin
          report_mismatch($sformatf("worst_char got %02h, expected %02h",
                                    out_worst_char, worst_letters_due[0]));
        end
        void'(worst_letters_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_item(input logic [CHAR_W-1:0] b, input logic has,
                           input logic last, input logic fail);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte_value  <= b;
    in_has_byte    <= has;
    in_is_last     <= last;
    in_eval_failed <= fail;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    if (s.len() == 0) send_item('0, 1'b0, 1'b1, 1'b0);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, i == s.len() - 1, 1'b0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (worst_letters_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, data);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CHAR_W-1:0] pool_letter();
    if ($urandom_range(4) == 0) return CHAR_W'($urandom_range(255));
    return POOL_BASE + CHAR_W'($urandom_range(9));
  endfunction

  function automatic logic [CHAR_W-1:0] token_letter();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(19) < 3) begin
      c = CHAR_W'($urandom_range(255));
    end else if ($urandom_range(2) == 0) begin
      c = pool_letter();
    end else begin
      c = list_letter($urandom_range(MAX_LEVELS - 1));
    end
    if (c == SEP_CHAR) c = COLON_CHAR;
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] plain_byte();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(255));
    if (c == SEP_CHAR) c = ~c;
    return c;
  endfunction

  task automatic randomise_config();
    logic [SEV_W-1:0]      letters;
    logic [CFG_DATA_W-1:0] noise;
    for (int i = 0; i < MAX_LEVELS; i++) letters[i*CHAR_W +: CHAR_W] = pool_letter();
    write_reg(CFG_SEVERITY, letters);
    noise = rand64();
    noise[LVLCNT_W-1:0] = ($urandom_range(3) == 0) ? LVLCNT_W'($urandom_range(15))
                                                    : LVLCNT_W'($urandom_range(1, 8));
    write_reg(CFG_LEVELS, noise);
    noise = rand64();
    noise[CHAR_W-1:0] = pool_letter();
    write_reg(CFG_UNKNOWN, noise);
    write_reg(CFG_UNDEFINED, rand64());
  endtask

  task automatic send_random_string();
    logic [CHAR_W-1:0] text[$];
    logic [CHAR_W-1:0] c;
    int                tokens;
    bit                empty_end;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        c = CHAR_W'($urandom_range(255));
        if ($urandom_range(3) == 0) c = $urandom_range(1) ? SEP_CHAR : COLON_CHAR;
        text.push_back(c);
      end
    end else begin
      tokens = $urandom_range(1, 4);
      for (int t = 0; t < tokens; t++) begin
        if (t != 0) text.push_back(SEP_CHAR);
        case ($urandom_range(9))
          0: ;
          1: text.push_back(token_letter());
          2: begin
            text.push_back(token_letter());
            c = plain_byte();
            if (c == COLON_CHAR) c = ~c;
            text.push_back(c);
          end
          default: begin
            text.push_back(token_letter());
            text.push_back(COLON_CHAR);
            repeat ($urandom_range(3)) text.push_back(plain_byte());
          end
        endcase
      end
      if ($urandom_range(7) == 0) text.push_back(SEP_CHAR);
    end
    empty_end = (text.size() == 0) || ($urandom_range(5) == 0);
    foreach (text[i]) begin
      if ($urandom_range(19) == 0) begin
        send_item(CHAR_W'($urandom), 1'b0, 1'b0, $urandom_range(9) == 0);
      end
      send_item(text[i], 1'b1, !empty_end && (i == text.size() - 1), $urandom_range(49) == 0);
    end
    if (empty_end) send_item(CHAR_W'($urandom), 1'b0, 1'b1, $urandom_range(49) == 0);
  endtask

  task automatic test_reset_defaults();
    send_text("");
  endtask

  task automatic test_token_shapes();
    write_reg(CFG_SEVERITY, CFG_DATA_W'("IWEF"));
    write_reg(CFG_LEVELS, CFG_DATA_W'(4));
    write_reg(CFG_UNKNOWN, CFG_DATA_W'("W"));
    write_reg(CFG_UNDEFINED, CFG_DATA_W'("?"));
    send_text("I:o");
    send_text("E/");
    send_text("EX");
    send_item(8'hFF, 1'b0, 1'b0, 1'b0);
    send_text("F:");
    send_item("F", 1'b1, 1'b0, 1'b1);
    send_item(COLON_CHAR, 1'b1, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0, 1'b0);
    send_item(COLON_CHAR, 1'b1, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1, 1'b1);
    // abandon a half-scanned string with a write to an unused index
    send_item("F", 1'b1, 1'b0, 1'b0);
    send_item(COLON_CHAR, 1'b1, 1'b0, 1'b0);
    write_reg(CFG_SPARE, rand64());
    send_text("I:");
  endtask

  task automatic test_list_edges();
    write_reg(CFG_SEVERITY, CFG_DATA_W'("WWEE"));
    send_text("E:");
    write_reg(CFG_LEVELS, 64'hFFFF_FFFF_FFFF_FFF0);
    send_text("W:");
    write_reg(CFG_SEVERITY, CFG_DATA_W'("HGFEDCBA"));
    write_reg(CFG_LEVELS, CFG_DATA_W'(15));
    send_text("C:/D");
    write_reg(CFG_SEVERITY, '1);
    write_reg(CFG_UNKNOWN, CFG_DATA_W'(8'hFF));
    write_reg(CFG_UNDEFINED, CFG_DATA_W'(8'h00));
    send_text("");
  endtask

  task automatic test_random_traffic();
    int idle_pcts[4]  = '{0, 61, 0, 24};
    int stall_pcts[4] = '{0, 0, 61, 24};
    int start;
    for (int mode = 0; mode < 4; mode++) begin
      for (int round = 0; round < 2; round++) begin
        randomise_config();
        send_idle_pct  = idle_pcts[mode];
        recv_stall_pct = stall_pcts[mode];
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) send_random_string();
      end
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests <= hold_requests + 1;
    repeat (60) begin
      send_item(token_letter(), 1'b1, 1'b0, 1'b0);
      send_item(COLON_CHAR, 1'b1, 1'b1, 1'b0);
    end
  endtask

  initial begin
    sev_list         = '0;
    lvl_reg          = LVLCNT_W'(1);
    unknown_letter   = LETTER_E;
    undefined_letter = LETTER_E;
    restart_scan();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_token_shapes();
    test_list_edges();
    test_random_traffic();
    test_output_backpressure();
    in_valid <= 1'b0;
    while (worst_letters_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
